// ===== rtl/core/fixed_to_decimal_ascii_defines.svh =====
// assertion macros for the fixed-point to decimal text block
`ifndef FIXED_TO_DECIMAL_ASCII_DEFINES_SVH
`define FIXED_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef ASSERT_OFF
`define FDA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fda assertion failed");
`define FDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fda assertion failed");
`else
`define FDA_ASSERT(label, clk, rst_n, prop)
`define FDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/fda_pkg.sv =====
// shared constants, types and helper functions for the decimal text block
`timescale 1ns / 1ps

package fda_pkg;

    localparam int VALUE_W         = 32;
    localparam int FRAC_BITS       = 16;
    localparam int MAX_FRAC_DIGITS = 4;
    localparam int CFG_W           = 3;
    localparam int CHAR_W          = 8;

    localparam int INT_W = VALUE_W - FRAC_BITS;

    function automatic int num_digits(input longint v);
        int     n;
        longint p;
        begin
            n = 1;
            p = 10;
            while (p <= v)
            begin
                n = n + 1;
                p = p * 10;
            end
            return n;
        end
    endfunction

    function automatic longint pow10_const(input int n);
        longint p;
        begin
            p = 1;
            for (int i = 0; i < n; i++)
            begin
                p = p * 10;
            end
            return p;
        end
    endfunction

    localparam int INT_DIGITS = num_digits(longint'(1) << (INT_W - 1));
    localparam int POW10_W    = $clog2(pow10_const(MAX_FRAC_DIGITS) + 1);
    localparam int PROD_W     = FRAC_BITS + POW10_W;
    localparam int DD_W       = (INT_W > POW10_W) ? INT_W : POW10_W;
    localparam int DD_CNT_W   = $clog2(DD_W + 1);
    localparam int INT_IDX_W  = (INT_DIGITS > 1) ? $clog2(INT_DIGITS) : 1;
    localparam int FRAC_IDX_W = (MAX_FRAC_DIGITS > 1) ? $clog2(MAX_FRAC_DIGITS) : 1;
    localparam int IDX_W      = (INT_IDX_W > FRAC_IDX_W) ? INT_IDX_W : FRAC_IDX_W;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    // character kind selects
    localparam logic [1:0] SEL_MINUS = 2'd0;
    localparam logic [1:0] SEL_INT   = 2'd1;
    localparam logic [1:0] SEL_POINT = 2'd2;
    localparam logic [1:0] SEL_FRAC  = 2'd3;

    typedef struct packed {
        logic             load_in;
        logic             mult;
        logic             fix;
        logic             shift;
        logic             load_out;
        logic [1:0]       sel;
        logic [IDX_W-1:0] idx;
        logic             last;
        logic [CFG_W-1:0] digits;
    } fda_cmd_t;

    typedef struct packed {
        logic                 neg;
        logic [INT_IDX_W-1:0] int_lead;
    } fda_status_t;

    function automatic logic [CFG_W-1:0] clamp_digits(input logic [CFG_W-1:0] d);
        logic [CFG_W-1:0] r;
        begin
            if (d == '0)
                r = CFG_W'(1);
            else if (d > CFG_W'(MAX_FRAC_DIGITS))
                r = CFG_W'(MAX_FRAC_DIGITS);
            else
                r = d;
            return r;
        end
    endfunction

    function automatic logic [POW10_W-1:0] pow10_sel(input logic [CFG_W-1:0] d);
        logic [POW10_W-1:0] r;
        begin
            r = '0;
            for (int i = 0; i <= MAX_FRAC_DIGITS; i++)
            begin
                if (d == CFG_W'(i))
                    r = POW10_W'(pow10_const(i));
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/fda_datapath.sv =====
// datapath: magnitude, fraction scaling and rounding, binary to bcd, character select
`timescale 1ns / 1ps

module fda_datapath (
    input  logic                          clk,
    input  logic [fda_pkg::VALUE_W-1:0]   value,
    input  fda_pkg::fda_cmd_t             cmd,
    output fda_pkg::fda_status_t          status,
    output logic [fda_pkg::CHAR_W-1:0]    char_code,
    output logic                          last
);
    import fda_pkg::*;

    localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    logic                        neg_reg;
    logic [VALUE_W-1:0]          mag_reg;
    logic [POW10_W-1:0]          pow10_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic [DD_W-1:0]             ibin_reg;
    logic [DD_W-1:0]             fbin_reg;
    logic [INT_DIGITS*4-1:0]     ibcd_reg;
    logic [MAX_FRAC_DIGITS*4-1:0] fbcd_reg;
    logic [CHAR_W-1:0]           char_reg;
    logic                        last_reg;

    logic [PROD_W:0]             round_sum;
    logic [POW10_W:0]            fr_wide;
    logic                        carry;
    logic [INT_W-1:0]            ipart;
    logic [POW10_W-1:0]          fpart;
    logic [INT_DIGITS*4-1:0]     ibcd_adj;
    logic [MAX_FRAC_DIGITS*4-1:0] fbcd_adj;
    logic [INT_IDX_W-1:0]        lead;
    logic [3:0]                  idig;
    logic [3:0]                  fdig;
    logic [CHAR_W-1:0]           char_next;

    // rounding of the scaled fraction may carry into the integer part
    assign round_sum = {1'b0, prod_reg} + HALF;
    assign fr_wide   = round_sum[PROD_W:FRAC_BITS];
    assign carry     = (fr_wide == {1'b0, pow10_reg});
    assign ipart     = mag_reg[VALUE_W-1:FRAC_BITS] + INT_W'(carry);
    assign fpart     = carry ? '0 : fr_wide[POW10_W-1:0];

    always_comb
    begin
        for (int i = 0; i < INT_DIGITS; i++)
        begin
            if (ibcd_reg[4*i +: 4] >= 4'd5)
                ibcd_adj[4*i +: 4] = ibcd_reg[4*i +: 4] + 4'd3;
            else
                ibcd_adj[4*i +: 4] = ibcd_reg[4*i +: 4];
        end
        for (int i = 0; i < MAX_FRAC_DIGITS; i++)
        begin
            if (fbcd_reg[4*i +: 4] >= 4'd5)
                fbcd_adj[4*i +: 4] = fbcd_reg[4*i +: 4] + 4'd3;
            else
                fbcd_adj[4*i +: 4] = fbcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < INT_DIGITS; i++)
        begin
            if (ibcd_reg[4*i +: 4] != 4'd0)
                lead = INT_IDX_W'(i);
        end
    end

    assign idig = ibcd_reg[cmd.idx[INT_IDX_W-1:0]*4 +: 4];
    assign fdig = fbcd_reg[cmd.idx[FRAC_IDX_W-1:0]*4 +: 4];

    always_comb
    begin
        unique case (cmd.sel)
            SEL_MINUS: char_next = CH_MINUS;
            SEL_INT:   char_next = CH_ZERO + CHAR_W'(idig);
            SEL_POINT: char_next = CH_POINT;
            SEL_FRAC:  char_next = CH_ZERO + CHAR_W'(fdig);
            default:   char_next = CH_POINT;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            neg_reg   <= value[VALUE_W-1];
            mag_reg   <= value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
            pow10_reg <= pow10_sel(cmd.digits);
        end
        if (cmd.mult)
            prod_reg <= PROD_W'(mag_reg[FRAC_BITS-1:0]) * PROD_W'(pow10_reg);
        if (cmd.fix)
        begin
            ibin_reg <= DD_W'(ipart);
            fbin_reg <= DD_W'(fpart);
            ibcd_reg <= '0;
            fbcd_reg <= '0;
        end
        else if (cmd.shift)
        begin
            ibcd_reg <= {ibcd_adj[INT_DIGITS*4-2:0], ibin_reg[DD_W-1]};
            fbcd_reg <= {fbcd_adj[MAX_FRAC_DIGITS*4-2:0], fbin_reg[DD_W-1]};
            ibin_reg <= {ibin_reg[DD_W-2:0], 1'b0};
            fbin_reg <= {fbin_reg[DD_W-2:0], 1'b0};
        end
        if (cmd.load_out)
        begin
            char_reg <= char_next;
            last_reg <= cmd.last;
        end
    end

    assign status.neg      = neg_reg;
    assign status.int_lead = lead;
    assign char_code       = char_reg;
    assign last            = last_reg;

endmodule

// ===== rtl/core/fda_ctrl.sv =====
// controller: item sequencing, conversion count, character order, output valid, config register
`timescale 1ns / 1ps

module fda_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic                        cfg_wr_en,
    input  logic [fda_pkg::CFG_W-1:0]   cfg_wr_data,
    input  fda_pkg::fda_status_t        status,
    output fda_pkg::fda_cmd_t           cmd
);
    import fda_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_FIX  = 3'd2;
    localparam logic [2:0] ST_CONV = 3'd3;
    localparam logic [2:0] ST_LEAD = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]          state_reg,       state_next;
    logic [1:0]          phase_reg,       phase_next;
    logic [IDX_W-1:0]    idx_reg,         idx_next;
    logic [DD_CNT_W-1:0] cnt_reg,         cnt_next;
    logic [CFG_W-1:0]    frac_digits_reg;
    logic                m_valid_reg,     m_valid_next;
    logic [CFG_W-1:0]    eff_digits;
    logic                out_free;

    assign eff_digits = clamp_digits(frac_digits_reg);
    assign out_free   = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.digits = eff_digits;
        cmd.sel    = phase_reg;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                cnt_next   = '0;
                state_next = ST_CONV;
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg + DD_CNT_W'(1);
                if (cnt_reg == DD_CNT_W'(DD_W - 1))
                    state_next = ST_LEAD;
            end
            ST_LEAD:
            begin
                idx_next   = IDX_W'(status.int_lead);
                phase_next = status.neg ? SEL_MINUS : SEL_INT;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    case (phase_reg)
                        SEL_MINUS:
                        begin
                            phase_next = SEL_INT;
                        end
                        SEL_INT:
                        begin
                            if (idx_reg == '0)
                                phase_next = SEL_POINT;
                            else
                                idx_next = idx_reg - IDX_W'(1);
                        end
                        SEL_POINT:
                        begin
                            phase_next = SEL_FRAC;
                            idx_next   = IDX_W'(eff_digits - CFG_W'(1));
                        end
                        default:
                        begin
                            cmd.last = (idx_reg == '0);
                            if (idx_reg == '0)
                                state_next = ST_IDLE;
                            else
                                idx_next = idx_reg - IDX_W'(1);
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= SEL_MINUS;
            idx_reg         <= '0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
            frac_digits_reg <= CFG_W'(2);
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
                frac_digits_reg <= cfg_wr_data;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

// ===== rtl/core/fixed_to_decimal_ascii.sv =====
// the input beat passes multiply, fix, bcd shift and lead states before the first character
// each value gives n characters (3 to 11), one value at a time
// a 16-step binary to bcd shift loop, then one character per cycle while the output is free
// reset: asynchronous active low, clears control and output valid, frac_digits returns to 2
`timescale 1ns / 1ps
`include "fixed_to_decimal_ascii_defines.svh"

module fixed_to_decimal_ascii (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [fda_pkg::VALUE_W-1:0] s_tdata,     // value
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [fda_pkg::CHAR_W-1:0]  m_tdata,     // char_code
    output logic                        m_tlast,
    input  logic                        cfg_wr_en,
    input  logic [fda_pkg::CFG_W-1:0]   cfg_wr_data  // frac_digits
);
    import fda_pkg::*;

    fda_cmd_t    cmd;
    fda_status_t status;

    fda_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .status      (status),
        .cmd         (cmd)
    );

    fda_datapath u_datapath (
        .clk       (clk),
        .value     (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .char_code (m_tdata),
        .last      (m_tlast)
    );

    `FDA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `FDA_ASSERT(a_load_into_free_slot, clk, rst_n, !cmd.load_out || !m_tvalid || m_tready)
    `FDA_ASSERT_NEXT(a_idle_after_last, clk, rst_n, cmd.load_out && cmd.last, s_tready && m_tvalid && m_tlast)
    `FDA_ASSERT(a_accept_after_last, clk, rst_n, !(s_tvalid && s_tready) || !m_tvalid || m_tlast)

endmodule

// ===== tb/tb.sv =====
// testbench for fixed_to_decimal_ascii: predicts the text of each value and checks every character beat
`timescale 1ns / 1ps

module tb;

    import fda_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_PAD    = 40;
    localparam int RAND_PER_SET = 24;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    class ascii_text_scoreboard;
        text_char_t text_q[$];
        int         failures;

        function new();
            failures = 0;
        endfunction

        function int pending();
            return text_q.size();
        endfunction

        function void push_char(logic [CHAR_W-1:0] code, logic last);
            text_char_t c;
            c.code = code;
            c.last = last;
            text_q.push_back(c);
        endfunction

        function void note_value(logic [VALUE_W-1:0] value, logic [CFG_W-1:0] digits_reg);
            logic            neg;
            longint unsigned mag;
            longint unsigned p10;
            longint unsigned scaled;
            longint unsigned ipart;
            longint unsigned fpart;
            int              nd;
            int              int_q[$];
            neg = value[VALUE_W-1];
            mag = neg ? (64'h1_0000_0000 - {32'h0, value}) : {32'h0, value};
            if (digits_reg == 0)
                nd = 1;
            else if (digits_reg > MAX_FRAC_DIGITS)
                nd = MAX_FRAC_DIGITS;
            else
                nd = digits_reg;
            p10 = 1;
            repeat (nd) p10 = p10 * 10;
            scaled = (mag * p10 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            ipart = scaled / p10;
            fpart = scaled % p10;
            if (neg)
                push_char(CH_MINUS, 1'b0);
            do
            begin
                int_q.push_front(int'(ipart % 10));
                ipart = ipart / 10;
            end
            while (ipart != 0);
            foreach (int_q[i])
                push_char(CH_ZERO + CHAR_W'(int_q[i]), 1'b0);
            push_char(CH_POINT, 1'b0);
            for (int i = 0; i < nd; i++)
            begin
                p10 = p10 / 10;
                push_char(CH_ZERO + CHAR_W'((fpart / p10) % 10), i == nd - 1);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] code, logic last);
            text_char_t want;
            if (text_q.size() == 0)
            begin
                $display("%0t: unexpected char beat, expected none, actual %h last %b",
                         $time, code, last);
                failures++;
                return;
            end
            want = text_q.pop_front();
            if (code !== want.code)
            begin
                $display("%0t: char_code mismatch, expected %h, actual %h",
                         $time, want.code, code);
                failures++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last mismatch, expected %b, actual %b", $time, want.last, last);
                failures++;
            end
        endfunction
    endclass

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata     = '0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [CHAR_W-1:0]   m_tdata;
    logic                m_tlast;
    logic                cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data = '0;

    ascii_text_scoreboard sb = new();
    logic [CFG_W-1:0]     digits_shadow = CFG_W'(2);
    bit                   tx_idle = 1'b0;
    bit                   rx_idle = 1'b0;
    bit                   rx_hold_req = 1'b0;
    int                   rx_hold = 0;
    int                   rx_gap = 0;
    int                   cycles = 0;

    fixed_to_decimal_ascii dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // character sink with random and long stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                sb.check_char(m_tdata, m_tlast);
                rx_gap = rx_idle ? $urandom_range(0, 12) : 0;
            end
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rx_hold = LONG_HOLD;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        gap = tx_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_value(value, digits_shadow);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_digits(input logic [CFG_W-1:0] d);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= d;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        digits_shadow = d;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4:          v = $urandom_range(0, 32'h3FFFF);
            5:          v = -VALUE_W'($urandom_range(1, 400));
            6:          v = {VALUE_W'($urandom_range(0, 120)) << FRAC_BITS} | $urandom_range(0, 16'hFFFF);
            7:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'hFFFF_FFFF;
                    3:       v = 32'h0000_0000;
                    default: v = 32'h0000_0001;
                endcase
            end
            8:          v = {16'd9999, 16'hFF00 | 16'($urandom_range(0, 255))};
            default:    v = {$urandom} | 32'h8000_0000;
        endcase
        if ($urandom_range(0, 3) == 0)
            v = -v;
        return v;
    endfunction

    logic [VALUE_W-1:0] directed_values[] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_8000,
        32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h8000_0001, 32'h7FFF_0000, 32'h000A_0000, 32'h0009_FFFF, 32'h0000_0147,
        32'h0000_0148, 32'hFFFF_FEB9, 32'h0003_243F, 32'hFFFC_DBC1, 32'h5555_5555,
        32'hAAAA_AAAA, 32'h0000_2000, 32'hFFFF_E000
    };

    logic [CFG_W-1:0] digit_sets[] = '{3'd4, 3'd0, 3'd7, 3'd1, 3'd3, 3'd5, 3'd6, 3'd2};

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting, no idling
        foreach (directed_values[i])
            send_value(directed_values[i]);
        wait_idle();

        foreach (digit_sets[p])
        begin
            write_digits(digit_sets[p]);
            tx_idle = (p % 4 == 0) || (p % 4 == 2);
            rx_idle = (p % 4 == 0) || (p % 4 == 1);
            if (p == 2)
            begin
                tx_idle = 1'b0;
                rx_hold_req = 1'b1;
            end
            for (int i = 0; i < RAND_PER_SET; i++)
            begin
                if (p == 4 && i == RAND_PER_SET / 2)
                    wait_idle();
                send_value(pick_value());
            end
            wait_idle();
        end

        if (sb.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
